>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, written out in prop
`define IFT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ift assertion failed");

// antecedent now, consequent in the next cycle
`define IFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ift assertion failed");

`endif

>>> rtl/ift_pkg.sv
// ----------------------------------------------------------------------------
// ift_pkg
// Types and constants of the IPv4 flow tracker.
// ----------------------------------------------------------------------------
package ift_pkg;

  typedef enum logic [2:0] {
    ST_NEW        = 3'd0,
    ST_UPDATED    = 3'd1,
    ST_NOT_IPV4   = 3'd2,
    ST_FRAGMENT   = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_TOO_SHORT  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_CMP
  } back_state_e;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] FRAG_MF       = 16'h2000;
  localparam logic [15:0] FRAG_OFS_MASK = 16'h1fff;
  localparam logic [7:0]  TCP_FLAG_SYN  = 8'h02;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam int          ETH_HDR_LEN   = 14;
  localparam int          IP_MIN_LEN    = 34;
  localparam int          L4_SLOT       = 34;
  localparam int          L4_CAP        = 14;
  localparam int          UDP_MIN_LEN   = 4;
  localparam int          CAP_BYTES     = 48;

  typedef struct packed {
    status_e      status;
    logic [3:0]   flow_index;
    logic [47:0]  dst_mac;
    logic [47:0]  src_mac;
    logic [31:0]  src_ip;
    logic [31:0]  dst_ip;
    logic [7:0]   protocol;
    logic [15:0]  src_l4_port;
    logic [15:0]  dst_l4_port;
    logic [31:0]  seq_number;
    logic [31:0]  ack_number;
    logic [16:0]  payload_len;
  } result_t;

  // lookup = 0: result is final as parsed
  typedef struct packed {
    logic    lookup;
    result_t res;
  } job_t;

endpackage

>>> rtl/ift_byte_if.sv
// ----------------------------------------------------------------------------
// ift_byte_if
// Frame byte channel.
// ----------------------------------------------------------------------------
interface ift_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

>>> rtl/ift_result_if.sv
// ----------------------------------------------------------------------------
// ift_result_if
// Per-frame result channel.
// ----------------------------------------------------------------------------
interface ift_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  flow_index;
  logic [47:0] dst_mac;
  logic [47:0] src_mac;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [7:0]  protocol;
  logic [15:0] src_l4_port;
  logic [15:0] dst_l4_port;
  logic [31:0] seq_number;
  logic [31:0] ack_number;
  logic [16:0] payload_len;

  modport source (output valid, output status, output flow_index, output dst_mac,
                  output src_mac, output src_ip, output dst_ip, output protocol,
                  output src_l4_port, output dst_l4_port, output seq_number,
                  output ack_number, output payload_len, input ready);
  modport sink   (input valid, input status, input flow_index, input dst_mac,
                  input src_mac, input src_ip, input dst_ip, input protocol,
                  input src_l4_port, input dst_l4_port, input seq_number,
                  input ack_number, input payload_len, output ready);
endinterface

>>> rtl/ift_queue.sv
// ----------------------------------------------------------------------------
// ift_queue
// Two-entry job queue between the parser and the flow table.
// ----------------------------------------------------------------------------
module ift_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ift_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ift_pkg::job_t pop_job_o
);
  import ift_pkg::*;

  job_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_job_o    = slot_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= push_job_i;
  end

endmodule

>>> rtl/ift_front.sv
// ----------------------------------------------------------------------------
// ift_front
// Byte parser: captures header bytes and classifies the frame on its last byte.
// ----------------------------------------------------------------------------
module ift_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ift_byte_if.sink      in_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output ift_pkg::job_t push_job_o
);
  import ift_pkg::*;

  logic [15:0] pos_q;
  logic [7:0]  cap_q [CAP_BYTES];
  logic [7:0]  cap_d [CAP_BYTES];
  logic [3:0]  ihl;
  logic [6:0]  l4;
  logic [15:0] l4_ofs;
  logic [16:0] n;
  logic [15:0] tlen, frag, seg, seg_len, hdr_len, doff;
  logic [16:0] tcp_len;
  logic [7:0]  proto;
  logic        accept;
  job_t        job;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid && in_i.last_byte;
  assign push_job_o   = job;
  assign accept       = in_i.valid && in_i.ready;

  // capture update for the byte on the port
  always_comb begin
    cap_d = cap_q;
    if (pos_q < 16'(IP_MIN_LEN)) cap_d[pos_q[5:0]] = in_i.frame_byte;
    ihl    = cap_d[14][3:0];
    l4     = 7'(ETH_HDR_LEN) + {1'b0, ihl, 2'b00};
    l4_ofs = pos_q - {9'd0, l4};
    if (pos_q >= {9'd0, l4} && l4_ofs < 16'(L4_CAP)) begin
      cap_d[6'(L4_SLOT) + l4_ofs[5:0]] = in_i.frame_byte;
    end
  end

  always_comb begin
    n       = {1'b0, pos_q} + 17'd1;
    tlen    = {cap_d[16], cap_d[17]};
    frag    = {cap_d[20], cap_d[21]};
    proto   = cap_d[23];
    hdr_len = {10'd0, ihl, 2'b00};
    doff    = {10'd0, cap_d[L4_SLOT + 12][7:4], 2'b00};
    seg     = (tlen >= hdr_len) ? tlen - hdr_len : 16'd0;
    seg_len = (seg >= doff) ? seg - doff : 16'd0;
    tcp_len = {1'b0, seg_len} + {16'd0, (cap_d[L4_SLOT + 13] & TCP_FLAG_SYN) != 8'd0};

    job = '0;
    job.res.status = ST_TOO_SHORT;
    if (n >= 17'(ETH_HDR_LEN)) begin
      job.res.dst_mac = {cap_d[0], cap_d[1], cap_d[2], cap_d[3], cap_d[4], cap_d[5]};
      job.res.src_mac = {cap_d[6], cap_d[7], cap_d[8], cap_d[9], cap_d[10], cap_d[11]};
      if ({cap_d[12], cap_d[13]} != ETH_TYPE_IPV4) begin
        job.res.status = ST_NOT_IPV4;
      end else if (n < 17'(IP_MIN_LEN)) begin
        job.res = '0;
        job.res.status = ST_TOO_SHORT;
      end else begin
        job.res.src_ip   = {cap_d[26], cap_d[27], cap_d[28], cap_d[29]};
        job.res.dst_ip   = {cap_d[30], cap_d[31], cap_d[32], cap_d[33]};
        job.res.protocol = proto;
        if ((frag & FRAG_MF) != 16'd0 || (frag & FRAG_OFS_MASK) != 16'd0) begin
          job.res.status = ST_FRAGMENT;
        end else if ((proto == PROTO_TCP && n < {10'd0, l4} + 17'(L4_CAP)) ||
                     (proto == PROTO_UDP && n < {10'd0, l4} + 17'(UDP_MIN_LEN))) begin
          job.res = '0;
          job.res.status = ST_TOO_SHORT;
        end else begin
          job.lookup = 1'b1;
          job.res.status = ST_NEW;
          if (proto == PROTO_TCP || proto == PROTO_UDP) begin
            job.res.src_l4_port = {cap_d[L4_SLOT], cap_d[L4_SLOT + 1]};
            job.res.dst_l4_port = {cap_d[L4_SLOT + 2], cap_d[L4_SLOT + 3]};
          end
          if (proto == PROTO_TCP) begin
            job.res.seq_number  = {cap_d[L4_SLOT + 4], cap_d[L4_SLOT + 5],
                                   cap_d[L4_SLOT + 6], cap_d[L4_SLOT + 7]};
            job.res.ack_number  = {cap_d[L4_SLOT + 8], cap_d[L4_SLOT + 9],
                                   cap_d[L4_SLOT + 10], cap_d[L4_SLOT + 11]};
            job.res.payload_len = tcp_len;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      for (int i = 0; i < CAP_BYTES; i++) cap_q[i] <= '0;
    end else if (accept) begin
      if (in_i.last_byte) begin
        pos_q <= '0;
        for (int i = 0; i < CAP_BYTES; i++) cap_q[i] <= '0;
      end else begin
        if (pos_q != 16'hffff) pos_q <= pos_q + 16'd1;
        cap_q <= cap_d;
      end
    end
  end

endmodule

>>> rtl/ift_back.sv
// ----------------------------------------------------------------------------
// ift_back
// Flow table: linear four-tuple search, insert on miss if not full, result register.
// ----------------------------------------------------------------------------
module ift_back #(
  parameter int MAX_FLOWS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  ift_pkg::job_t    pop_job_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ift_pkg::result_t out_res_o
);
  import ift_pkg::*;

  localparam int IDX_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
  localparam int CNT_W = $clog2(MAX_FLOWS + 1);

  back_state_e      state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d, cnt_q, cnt_d;
  job_t             job_q, job_d;
  result_t          out_q, out_d;
  logic             ov_q, ov_d;
  logic             pop, key_we, st_we;
  logic [IDX_W-1:0] wr_idx;
  logic [95:0]      key, rd_key_q;
  logic [95:0]      key_mem [MAX_FLOWS];
  logic [80:0]      st_mem  [MAX_FLOWS];

  assign key = {job_q.res.src_ip, job_q.res.dst_ip, job_q.res.src_l4_port,
                job_q.res.dst_l4_port};
  assign pop_ready_o = pop;
  assign out_valid_o = ov_q;
  assign out_res_o   = out_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    job_d   = job_q;
    out_d   = out_q;
    ov_d    = ov_q && !out_ready_i;
    pop     = 1'b0;
    key_we  = 1'b0;
    st_we   = 1'b0;
    wr_idx  = idx_q[IDX_W-1:0];
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i && !ov_q) begin
          pop   = 1'b1;
          job_d = pop_job_i;
          if (pop_job_i.lookup) begin
            idx_d   = '0;
            state_d = B_READ;
          end else begin
            out_d = pop_job_i.res;
            ov_d  = 1'b1;
          end
        end
      end
      B_READ: begin
        if (idx_q == cnt_q) begin
          // searched every entry in use
          out_d   = job_q.res;
          ov_d    = 1'b1;
          state_d = B_IDLE;
          if (cnt_q < CNT_W'(MAX_FLOWS)) begin
            key_we           = 1'b1;
            st_we            = 1'b1;
            wr_idx           = cnt_q[IDX_W-1:0];
            cnt_d            = cnt_q + 1'b1;
            out_d.status     = ST_NEW;
            out_d.flow_index = 4'(cnt_q);
          end else begin
            out_d.status     = ST_TABLE_FULL;
            out_d.flow_index = '0;
          end
        end else begin
          state_d = B_CMP;
        end
      end
      B_CMP: begin
        if (rd_key_q == key) begin
          out_d            = job_q.res;
          out_d.status     = ST_UPDATED;
          out_d.flow_index = 4'(idx_q);
          ov_d             = 1'b1;
          st_we            = 1'b1;
          state_d          = B_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = B_READ;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  // table storage, one write port, registered read
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[wr_idx] <= key;
    if (st_we)  st_mem[wr_idx]  <= {job_q.res.seq_number, job_q.res.ack_number,
                                     job_q.res.payload_len};
    rd_key_q <= key_mem[idx_q[IDX_W-1:0]];
  end

endmodule

>>> rtl/ipv4_flow_tracker.sv
// ----------------------------------------------------------------------------
// ipv4_flow_tracker
// Ethernet/IPv4/TCP/UDP header parser with a four-tuple flow table.
// ----------------------------------------------------------------------------
//   channel  dir  payload                      transaction
//   in_i     in   frame_byte, last_byte        one frame byte
//   res_o    out  status .. payload_len        one result per frame
//
// Bytes are taken one per cycle; every byte stalls while the two-entry
// job queue is full.
// A lookup reads and compares the entries in use in order, one table read and
// one compare per entry, until a hit or until all flows in use are searched;
// other results go straight to the output register.
// The flow table needs no clearing pass: entries beyond the fill count are
// never compared. Reset clears the capture, the fill count and all handshakes.
// ----------------------------------------------------------------------------
module ipv4_flow_tracker #(
  parameter int MAX_FLOWS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ift_byte_if.sink     in_i,
  ift_result_if.source res_o
);
  import ift_pkg::*;

  logic    push_valid, push_ready, pop_valid, pop_ready, out_valid;
  job_t    push_job, pop_job;
  result_t out_res;

  ift_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  ift_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  ift_back #(.MAX_FLOWS(MAX_FLOWS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_valid_o (out_valid),
    .out_ready_i (res_o.ready),
    .out_res_o   (out_res)
  );

  assign res_o.valid       = out_valid;
  assign res_o.status      = out_res.status;
  assign res_o.flow_index  = out_res.flow_index;
  assign res_o.dst_mac     = out_res.dst_mac;
  assign res_o.src_mac     = out_res.src_mac;
  assign res_o.src_ip      = out_res.src_ip;
  assign res_o.dst_ip      = out_res.dst_ip;
  assign res_o.protocol    = out_res.protocol;
  assign res_o.src_l4_port = out_res.src_l4_port;
  assign res_o.dst_l4_port = out_res.dst_l4_port;
  assign res_o.seq_number  = out_res.seq_number;
  assign res_o.ack_number  = out_res.ack_number;
  assign res_o.payload_len = out_res.payload_len;

endmodule

>>> rtl/ift_checker.sv
// ----------------------------------------------------------------------------
// ift_checker
// Port-level checks of the flow tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ift_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic [3:0]  flow_index_i,
  input logic [7:0]  protocol_i,
  input logic [31:0] seq_number_i,
  input logic [16:0] payload_len_i
);
  import ift_pkg::*;

  `IFT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(status_i) && $stable(flow_index_i))

  `IFT_ASSERT(a_status_range, clk_i, rst_ni, out_valid_i |-> status_i <= ST_TOO_SHORT)

  `IFT_ASSERT(a_index_unused, clk_i, rst_ni,
              out_valid_i && status_i != ST_NEW && status_i != ST_UPDATED |->
              flow_index_i == 4'd0)

  `IFT_ASSERT(a_tcp_only, clk_i, rst_ni,
              out_valid_i && protocol_i != PROTO_TCP |->
              seq_number_i == 32'd0 && payload_len_i == 17'd0)

endmodule

bind ipv4_flow_tracker ift_checker u_ift_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .status_i      (res_o.status),
  .flow_index_i  (res_o.flow_index),
  .protocol_i    (res_o.protocol),
  .seq_number_i  (res_o.seq_number),
  .payload_len_i (res_o.payload_len)
);
